// File: hdl/lkpq_pkg.sv
// ----------------------------------------------------------------------------
// lkpq_pkg
// Shared widths, codes and types for the last-k product query block.
// ----------------------------------------------------------------------------
package lkpq_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int VALUE_W       = 8;
  localparam int COUNT_W       = 11;
  localparam int PRODUCT_W     = 32;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } lkpq_state_t;

  // accumulator control: load seeds the accumulator, step multiplies in
  typedef struct packed {
    logic load;
    logic load_one;
    logic step;
  } mul_ctrl_t;

endpackage

// File: hdl/lkpq_store.sv
// ----------------------------------------------------------------------------
// lkpq_store
// Circular value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lkpq_store
  import lkpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [PTR_W-1:0]   wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [PTR_W-1:0]   rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/lkpq_mul.sv
// ----------------------------------------------------------------------------
// lkpq_mul
// Shared multiply-accumulate unit: acc <= acc * operand, modulo 2^32.
// ----------------------------------------------------------------------------
module lkpq_mul
  import lkpq_pkg::*;
(
  input  logic                 clk,
  input  mul_ctrl_t            ctrl,
  input  logic [VALUE_W-1:0]   operand,
  output logic [PRODUCT_W-1:0] acc
);

  logic [PRODUCT_W+VALUE_W-1:0] prod_full;

  assign prod_full = acc * operand;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= ctrl.load_one ? PRODUCT_W'(1) : '0;
    end else if (ctrl.step) begin
      acc <= prod_full[PRODUCT_W-1:0];
    end
  end

endmodule

// File: hdl/last_k_product_query.sv
// ----------------------------------------------------------------------------
// last_k_product_query
// Product of the last k values of an 8-bit stream, modulo 2^32.
// ----------------------------------------------------------------------------
// Keeps the most recent DEPTH values in a circular store. An add word gives
// no result; once the store is full the oldest value is overwritten. A query
// word with count k walks back through the k newest values, one store read
// and one 32x8 multiply per cycle through a single shared accumulator: the
// query is accepted, the k reads follow, the last multiply finishes in the
// drain state and the result register is loaded in the finish state. A
// query with k of zero or above the number of values held returns error
// with product 0. The input side is not ready while a query is in progress;
// adds are taken while a result waits at the output. The store has no reset
// and no clearing pass: a query only ever reads entries that were written.
// ----------------------------------------------------------------------------
module last_k_product_query
  import lkpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic [VALUE_W-1:0]   value,
  input  logic [COUNT_W-1:0]   count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PRODUCT_W-1:0] product,
  output logic                 error
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CMP_W  = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;

  lkpq_state_t state, state_next;

  logic [PTR_W-1:0]   write_ptr;
  logic [FILL_W-1:0]  fill_count;
  logic [PTR_W-1:0]   rd_addr;
  logic [FILL_W-1:0]  left;
  logic               rd_vld;
  logic               err_flag;

  logic               in_fire;
  logic               add_fire;
  logic               query_fire;
  logic               query_bad;
  logic               rd_en;
  logic               out_load;
  logic [VALUE_W-1:0] rd_data;
  logic [PRODUCT_W-1:0] acc;
  mul_ctrl_t          mul_ctrl;
  logic [PTR_W-1:0]   last_ptr;

  assign in_fire    = in_valid && in_ready;
  assign add_fire   = in_fire && (req_type == REQ_ADD);
  assign query_fire = in_fire && (req_type == REQ_QUERY);
  assign query_bad  = (count == '0) ||
                      (CMP_W'(count) > CMP_W'(fill_count));

  // newest entry sits one slot behind the write pointer
  assign last_ptr = (write_ptr == '0) ? PTR_W'(DEPTH - 1) : write_ptr - 1'b1;

  // ---- sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (query_fire) begin
          state_next = query_bad ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (left == FILL_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_RUN:    rd_en    = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: out_load = !out_valid || out_ready;
      default:   ;
    endcase
  end

  always_comb begin
    mul_ctrl.load     = query_fire;
    mul_ctrl.load_one = !query_bad;
    mul_ctrl.step     = rd_vld;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_ptr  <= '0;
      fill_count <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (add_fire) begin
        write_ptr <= (write_ptr == PTR_W'(DEPTH - 1)) ? '0 : write_ptr + 1'b1;
        if (fill_count != FILL_W'(DEPTH)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk pointer, word count and error flag
  always_ff @(posedge clk) begin
    if (query_fire) begin
      rd_addr  <= last_ptr;
      left     <= FILL_W'(count);
      err_flag <= query_bad;
    end else if (rd_en) begin
      rd_addr <= (rd_addr == '0) ? PTR_W'(DEPTH - 1) : rd_addr - 1'b1;
      left    <= left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      product <= acc;
      error   <= err_flag;
    end
  end

  lkpq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (add_fire),
    .wr_addr (write_ptr),
    .wr_data (value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lkpq_mul u_mul (
    .clk     (clk),
    .ctrl    (mul_ctrl),
    .operand (rd_data),
    .acc     (acc)
  );

  // ---- checks
  a_run_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (left != '0))
    else $error("walk running with no words left");

  a_rd_has_data: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (fill_count != '0))
    else $error("store read with nothing held");

  a_step_after_run: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> ($past(state) == ST_RUN))
    else $error("multiply step without a preceding read");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && err_flag) |-> (acc == '0))
    else $error("error result with non-zero product");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    add_fire |=> (fill_count != '0) && (fill_count <= FILL_W'(DEPTH)))
    else $error("fill count out of range after add");

endmodule
